// ----- design/dse_pkg.sv -----
// Shared types and constants for the two-point S0 estimator.
// Used by dse_log2 and diffusion_s0_two_point_estimate; depends on nothing.
package dse_pkg;

	localparam int DEFAULT_SAMPLE_BITS   = 16;
	localparam int DEFAULT_FRACTION_BITS = 8;

	localparam int B_W       = 14;             // b-value register width
	localparam int LOG_FRAC  = 24;             // fraction bits of log2 values
	localparam int LOG_INT_W = 5;              // integer bits of log2 values
	localparam int LOG_W     = LOG_INT_W + LOG_FRAC;
	localparam int NUM_W     = 44;             // rounded dividend width
	localparam int E_W       = 48;             // exponent word width
	localparam int OUT_W     = 32;
	localparam int SQRT_STEPS = 30;            // root bits resolved per square root
	localparam int EXP_PER   = SQRT_STEPS + 1; // one set-up stage plus the steps
	localparam int EXP_STAGES = LOG_FRAC * EXP_PER;

	typedef enum logic {
		REG_LOW_B  = 1'b0,
		REG_HIGH_B = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [NUM_W-1:0] numr;
		logic [B_W-1:0]   den;
		logic [B_W-1:0]   rem;
		logic [NUM_W-1:0] quo;
		logic             neg;
		logic [LOG_W-1:0] ll;
		logic             bad;
	} div_t;

	typedef struct packed {
		logic [30:0]         r;
		logic [61:0]         d;
		logic [LOG_FRAC-1:0] f;
		logic [7:0]          sh;
		logic                ovf;
		logic                tiny;
		logic                bad;
	} exp_t;

endpackage

// ----- design/dse_log2.sv -----
// Pipelined fixed-point log2 lane: normalise, then one squaring stage per fraction bit.
// Depends on dse_pkg.
module dse_log2 import dse_pkg::*; #(
	parameter int SAMPLE_BITS = DEFAULT_SAMPLE_BITS
) (
	input  logic                   clk,
	input  logic                   en,
	input  logic [SAMPLE_BITS-1:0] sample,
	output logic [LOG_W-1:0]       log_val
);

	localparam int N_W = $clog2(SAMPLE_BITS);

	logic [30:0]          y_s    [0:LOG_FRAC];
	logic [N_W-1:0]       n_s    [0:LOG_FRAC];
	logic [LOG_FRAC-1:0]  frac_s [0:LOG_FRAC];

	logic [N_W-1:0]            msb;
	logic [SAMPLE_BITS+29:0]   norm;

	// leading one, then scale to Q30 in [1,2)
	always_comb begin
		msb = '0;
		for (int i = 0; i < SAMPLE_BITS; i++) begin
			if (sample[i]) msb = N_W'(i);
		end
		norm = {sample, 30'b0} >> msb;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			y_s[0]    <= norm[30:0];
			n_s[0]    <= msb;
			frac_s[0] <= '0;
		end
	end

	for (genvar k = 1; k <= LOG_FRAC; k++) begin : g_sq
		logic [61:0] sq;
		logic [31:0] ys;
		always_comb begin
			sq = 62'(y_s[k-1]) * 62'(y_s[k-1]);
			ys = sq[61:30];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				y_s[k]    <= ys[31] ? ys[31:1] : ys[30:0];
				n_s[k]    <= n_s[k-1];
				frac_s[k] <= {frac_s[k-1][LOG_FRAC-2:0], ys[31]};
			end
		end
	end

	assign log_val = {LOG_INT_W'(n_s[LOG_FRAC]), frac_s[LOG_FRAC]};

endmodule

// ----- design/diffusion_s0_two_point_estimate.sv -----
// Top level of the two-point S0 estimator: log2 lanes, divider, exp2 square-root chain.
// Depends on dse_pkg and dse_log2.
//
// Usage: one voxel transaction on the input channel (signal_low, signal_high under
// in_valid / in_stall) yields exactly one transaction on the output channel
// (s0_estimate, estimate_valid, overflowed under out_valid / out_stall).
// The datapath is a single pipeline of 819 register stages: 25 for the two log2
// lanes (one squaring multiplier per fraction bit), 3 for difference, product and
// rounding, 44 for the one-bit-per-stage divider, 2 for exponent split, 744 for the
// exp2 unit (24 chained square roots, one root bit a stage) and 1 output register.
// Throughput is one voxel per cycle, every cycle, as long as the output side takes
// results.
// Reset (arst_n low) empties the pipeline and loads low_b = 100, high_b = 1000.
// When the receiver stalls with a result waiting, hold the whole pipeline: every
// stage freezes and in_stall rises in the same cycle, so nothing is dropped or
// repeated. Bubbles in the pipeline advance while the output register is empty.
// Write the b-value registers only while no transaction is in flight.
module diffusion_s0_two_point_estimate import dse_pkg::*; #(
	parameter int SAMPLE_BITS   = DEFAULT_SAMPLE_BITS,
	parameter int FRACTION_BITS = DEFAULT_FRACTION_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic                   cfg_index,
	input  logic [B_W-1:0]         cfg_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [SAMPLE_BITS-1:0] signal_low,
	input  logic [SAMPLE_BITS-1:0] signal_high,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [OUT_W-1:0]       s0_estimate,
	output logic                   estimate_valid,
	output logic                   overflowed
);

	// stage map along the valid line
	localparam int ST_D1   = LOG_FRAC + 1;
	localparam int ST_D2   = ST_D1 + 1;
	localparam int ST_D3   = ST_D2 + 1;
	localparam int ST_DIV  = ST_D3 + 1;
	localparam int ST_E1   = ST_DIV + NUM_W;
	localparam int ST_E2   = ST_E1 + 1;
	localparam int ST_EXP  = ST_E2 + 1;
	localparam int ST_OUT  = ST_EXP + EXP_STAGES;
	localparam int NSTG    = ST_OUT + 1;

	localparam logic signed [E_W-1:0] E_BIAS = E_W'(FRACTION_BITS) <<< LOG_FRAC;
	localparam logic signed [E_W-1:0] E_TOP  = 48'sd536870912;
	localparam logic signed [E_W-1:0] E_BOT  = -48'sd1073741824;

	logic [B_W-1:0] low_b_q, high_b_q;
	logic           adv;
	logic           vld_s [0:NSTG-1];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_b_q  <= B_W'(100);
			high_b_q <= B_W'(1000);
		end else if (cfg_wr_en) begin
			case (reg_idx_t'(cfg_index))
				REG_LOW_B:  low_b_q  <= cfg_data;
				REG_HIGH_B: high_b_q <= cfg_data;
				default:    ;
			endcase
		end
	end

	// advance everything unless a finished result is held
	assign adv      = !vld_s[ST_OUT] || !out_stall;
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NSTG; i++) vld_s[i] <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= in_valid;
			for (int i = 1; i < NSTG; i++) vld_s[i] <= vld_s[i-1];
		end
	end

	// ---- log2 lanes, with the invalid-input flag alongside
	logic [LOG_W-1:0] ll, lh;
	logic             bad_s [0:LOG_FRAC];

	dse_log2 #(.SAMPLE_BITS(SAMPLE_BITS)) u_log_low (
		.clk(clk), .en(adv), .sample(signal_low), .log_val(ll)
	);
	dse_log2 #(.SAMPLE_BITS(SAMPLE_BITS)) u_log_high (
		.clk(clk), .en(adv), .sample(signal_high), .log_val(lh)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			bad_s[0] <= (signal_low == '0) || (signal_high == '0) || (low_b_q == high_b_q);
			for (int i = 1; i <= LOG_FRAC; i++) bad_s[i] <= bad_s[i-1];
		end
	end

	// ---- difference, product, rounding offset
	logic signed [LOG_W:0] d_c;
	logic [LOG_W-1:0] ad_s1, ll_s1, ll_s2;
	logic [B_W-1:0]   den_s1, den_s2;
	logic             neg_s1, neg_s2, bad_s1, bad_s2;
	logic [NUM_W-2:0] num_s2;
	div_t             div_s [0:NUM_W];

	assign d_c = $signed({1'b0, lh}) - $signed({1'b0, ll});

	always_ff @(posedge clk) begin
		if (adv) begin
			ad_s1  <= d_c[LOG_W] ? LOG_W'(-d_c) : LOG_W'(d_c);
			neg_s1 <= d_c[LOG_W] != (low_b_q < high_b_q);
			den_s1 <= (low_b_q > high_b_q) ? low_b_q - high_b_q : high_b_q - low_b_q;
			ll_s1  <= ll;
			bad_s1 <= bad_s[LOG_FRAC];

			num_s2 <= (NUM_W-1)'(low_b_q) * (NUM_W-1)'(ad_s1);
			den_s2 <= den_s1;
			neg_s2 <= neg_s1;
			ll_s2  <= ll_s1;
			bad_s2 <= bad_s1;

			div_s[0].numr <= NUM_W'(num_s2) + NUM_W'(den_s2 >> 1);
			div_s[0].den  <= den_s2;
			div_s[0].rem  <= '0;
			div_s[0].quo  <= '0;
			div_s[0].neg  <= neg_s2;
			div_s[0].ll   <= ll_s2;
			div_s[0].bad  <= bad_s2;
		end
	end

	// ---- restoring divider, one quotient bit a stage, MSB first
	for (genvar j = 1; j <= NUM_W; j++) begin : g_div
		logic [B_W:0] trial;
		logic         take;
		div_t         nxt;
		always_comb begin
			trial   = {div_s[j-1].rem, div_s[j-1].numr[NUM_W-j]};
			take    = trial >= {1'b0, div_s[j-1].den};
			nxt     = div_s[j-1];
			nxt.rem = take ? B_W'(trial - {1'b0, div_s[j-1].den}) : B_W'(trial);
			nxt.quo = {div_s[j-1].quo[NUM_W-2:0], take};
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				div_s[j] <= nxt;
			end
		end
	end

	// ---- exponent, then split into integer shift and fraction
	logic signed [E_W-1:0] e_s1;
	logic                  bad_e1;
	logic signed [E_W-1:0] t_c;
	logic [7:0]            n8;
	exp_t                  exp_s [0:EXP_STAGES];

	always_comb begin
		if (div_s[NUM_W].neg)
			t_c = $signed(E_W'(div_s[NUM_W].ll)) - $signed(E_W'(div_s[NUM_W].quo));
		else
			t_c = $signed(E_W'(div_s[NUM_W].ll)) + $signed(E_W'(div_s[NUM_W].quo));
		n8 = e_s1[31:24];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			e_s1   <= t_c + E_BIAS;
			bad_e1 <= div_s[NUM_W].bad;

			exp_s[0].r    <= 31'(1) << 30;
			exp_s[0].d    <= '0;
			exp_s[0].f    <= e_s1[LOG_FRAC-1:0];
			exp_s[0].sh   <= 8'(8'sd30 - $signed(n8));
			exp_s[0].ovf  <= e_s1 >= E_TOP;
			exp_s[0].tiny <= e_s1 < E_BOT;
			exp_s[0].bad  <= bad_e1;
		end
	end

	// ---- exp2 of the fraction: per fraction bit, optional doubling then a square root
	for (genvar g = 1; g <= EXP_STAGES; g++) begin : g_exp
		localparam int K = (g - 1) / EXP_PER;
		localparam int S = (g - 1) % EXP_PER;
		if (S == 0) begin : g_init
			logic [31:0] xd;
			exp_t        nxt;
			always_comb begin
				xd    = exp_s[g-1].f[K] ? {exp_s[g-1].r, 1'b0} : {1'b0, exp_s[g-1].r};
				nxt   = exp_s[g-1];
				nxt.d = {xd, 30'b0} - (62'(1) << 60);
				nxt.r = 31'(1) << 30;
			end
			always_ff @(posedge clk) begin
				if (adv) begin
					exp_s[g] <= nxt;
				end
			end
		end else begin : g_step
			localparam int I = SQRT_STEPS - S;
			logic [61:0] tr;
			exp_t        nxt;
			always_comb begin
				tr  = (62'(exp_s[g-1].r) << (I + 1)) + (62'(1) << (2 * I));
				nxt = exp_s[g-1];
				if (exp_s[g-1].d >= tr) begin
					nxt.d = exp_s[g-1].d - tr;
					nxt.r = exp_s[g-1].r | (31'(1) << I);
				end
			end
			always_ff @(posedge clk) begin
				if (adv) begin
					exp_s[g] <= nxt;
				end
			end
		end
	end

	// ---- scale by the integer part, round half up, saturate
	exp_t                  fin;
	logic signed [7:0]     sh;
	logic [32:0]           rnd, val;
	logic [5:0]            amt;

	assign fin = exp_s[EXP_STAGES];
	assign sh  = $signed(fin.sh);

	always_comb begin
		amt = sh[5:0];
		rnd = 33'(fin.r) + (33'd1 << 6'(amt - 6'd1));
		if (sh >= 8'sd40)     val = '0;
		else if (sh > 8'sd0)  val = rnd >> amt;
		else if (sh == 8'sd0) val = 33'(fin.r);
		else                  val = 33'(fin.r) << 1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (fin.bad) begin
				s0_estimate    <= '0;
				estimate_valid <= 1'b0;
				overflowed     <= 1'b0;
			end else if (fin.ovf || val[32]) begin
				s0_estimate    <= '1;
				estimate_valid <= 1'b1;
				overflowed     <= 1'b1;
			end else if (fin.tiny) begin
				s0_estimate    <= '0;
				estimate_valid <= 1'b1;
				overflowed     <= 1'b0;
			end else begin
				s0_estimate    <= val[31:0];
				estimate_valid <= 1'b1;
				overflowed     <= 1'b0;
			end
		end
	end

	assign out_valid = vld_s[ST_OUT];

	// ---- checks
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !estimate_valid |-> s0_estimate == '0 && !overflowed)
		else $error("invalid estimate not cleared");

	a_ovf_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflowed |-> s0_estimate == '1 && estimate_valid)
		else $error("overflow without saturation");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with no held result");

endmodule

// ----- tb/sv/diffusion_s0_two_point_estimate_test.sv -----
// Self-checking testbench for the two-point S0 estimator (diffusion_s0_two_point_estimate).
// Depends on dse_pkg and the estimator RTL; an in-bench fixed-point predictor checks each result.
`timescale 1ns / 100ps

module diffusion_s0_two_point_estimate_test;
	import dse_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 900;    // a little above the 819-stage pipeline
	localparam int LONG_HOLD = 1500;      // receiver hold-off used to fill the pipeline

	typedef struct packed {
		logic [15:0] sig_lo;
		logic [15:0] sig_hi;
	} voxel_t;

	typedef struct packed {
		logic [31:0] s0;
		logic        vld;
		logic        ovf;
	} estimate_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_wr_en = 1'b0;
	reg_idx_t          cfg_index = REG_LOW_B;
	logic [B_W-1:0]    cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [15:0]       signal_low = '0;
	logic [15:0]       signal_high = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [OUT_W-1:0]  s0_estimate;
	logic              estimate_valid;
	logic              overflowed;

	// Configuration as the predictor sees it
	logic [B_W-1:0]    b_low_cur = 14'd100;
	logic [B_W-1:0]    b_high_cur = 14'd1000;

	voxel_t            voxels_pending[$];
	estimate_t         estimates_due[$];
	int                mismatches = 0;
	int                cycles = 0;
	int                burst_left = 0;
	int                gap_left = 0;
	bit                gaps_on = 1'b1;
	int                stall_mode = 0;
	bit                hold_req = 1'b0;
	bit                hold_done = 1'b0;
	int                hold_left = 0;

	diffusion_s0_two_point_estimate uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.signal_low(signal_low), .signal_high(signal_high),
		.out_valid(out_valid), .out_stall(out_stall),
		.s0_estimate(s0_estimate), .estimate_valid(estimate_valid), .overflowed(overflowed)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Bitwise integer square root
	function automatic logic [63:0] int_sqrt(logic [63:0] v);
		logic [63:0] root;
		logic [63:0] bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= root + bitv) begin
				v = v - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root;
	endfunction

	// log2 with 24 fraction bits by repeated squaring of the normalised mantissa
	function automatic longint log2_q24(logic [63:0] x);
		int msb;
		logic [63:0] y;
		logic [63:0] fr;
		msb = 0;
		fr = 0;
		while (msb < 63 && (x >> (msb + 1)) != 0) msb++;
		y = (x << 30) >> msb;
		for (int i = 0; i < LOG_FRAC; i++) begin
			y = (y * y) >> 30;
			fr = fr << 1;
			if (y >= (64'd1 << 31)) begin
				fr = fr | 64'd1;
				y = y >> 1;
			end
		end
		return longint'((64'(msb) << LOG_FRAC) | fr);
	endfunction

	// 2^f in Q30 through a chain of square roots, LSB first
	function automatic logic [63:0] pow2_frac(logic [23:0] f);
		logic [63:0] x;
		x = 64'd1 << 30;
		for (int k = 0; k < LOG_FRAC; k++) begin
			if (f[k]) x = x << 1;
			x = int_sqrt(x << 30);
		end
		return x;
	endfunction

	function automatic estimate_t extrapolate_s0(voxel_t v, logic [B_W-1:0] bl,
			logic [B_W-1:0] bh);
		estimate_t r;
		longint ll, lh, d, t, e, eb, n, shift;
		logic [63:0] ad, den, num, q, m, val;
		bit neg;
		r = '0;
		if (v.sig_lo == 0 || v.sig_hi == 0 || bl == bh) return r;
		ll = log2_q24(64'(v.sig_lo));
		lh = log2_q24(64'(v.sig_hi));
		d = lh - ll;
		ad = (d < 0) ? 64'(-d) : 64'(d);
		den = (bl > bh) ? 64'(bl - bh) : 64'(bh - bl);
		num = 64'(bl) * ad;
		q = (num + den / 2) / den;
		neg = (d < 0) != (bl < bh);
		t = neg ? ll - longint'(q) : ll + longint'(q);
		e = t + (longint'(8) <<< LOG_FRAC);
		r.vld = 1'b1;
		if (e >= (longint'(32) <<< LOG_FRAC)) begin
			r.s0 = '1;
			r.ovf = 1'b1;
			return r;
		end
		// vanishingly small: stays zero but valid
		if (e < -(longint'(64) <<< LOG_FRAC)) return r;
		eb = e + (longint'(64) <<< LOG_FRAC);
		n = (eb >>> LOG_FRAC) - 64;
		m = pow2_frac(eb[23:0]);
		shift = 30 - n;
		if (shift >= 40) val = 0;
		else if (shift > 0) val = (m + (64'd1 << (shift - 1))) >> shift;
		else if (shift == 0) val = m;
		else val = m << (-shift);
		if (val > 64'hFFFF_FFFF) begin
			r.s0 = '1;
			r.ovf = 1'b1;
		end else begin
			r.s0 = val[31:0];
		end
		return r;
	endfunction

	// Driver: advance the pending queue in bursts, hold the payload while stalled
	always @(posedge clk) begin
		if (in_valid && !in_stall) begin
			estimates_due.push_back(extrapolate_s0({signal_low, signal_high},
				b_low_cur, b_high_cur));
			void'(voxels_pending.pop_front());
		end
		if (!(in_valid && in_stall)) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (voxels_pending.size() > 0) begin
				in_valid <= 1'b1;
				signal_low <= voxels_pending[0].sig_lo;
				signal_high <= voxels_pending[0].sig_hi;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 30);
					gap_left <= gaps_on ? $urandom_range(0, 6) : 0;
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor: check each result transaction, then pick the next stall
	always @(posedge clk) begin
		estimate_t want;
		if (out_valid && !out_stall) begin
			if (estimates_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: s0=%h valid=%b ovf=%b",
						s0_estimate, estimate_valid, overflowed);
			end else begin
				want = estimates_due.pop_front();
				if (want.s0 !== s0_estimate || want.vld !== estimate_valid ||
						want.ovf !== overflowed) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp s0=%h valid=%b ovf=%b, got s0=%h valid=%b ovf=%b",
							want.s0, want.vld, want.ovf,
							s0_estimate, estimate_valid, overflowed);
				end
			end
		end
		if (hold_req && !hold_done) begin
			hold_done <= 1'b1;
			hold_left <= LONG_HOLD;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			case (stall_mode)
				1: out_stall <= ($urandom_range(0, 9) < 4);
				2: out_stall <= ((cycles % 11) < 4);
				default: out_stall <= 1'b0;
			endcase
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic logic [15:0] pick_sample();
		case ($urandom_range(0, 19))
			0: return 16'd0;
			1: return 16'($urandom_range(1, 15));
			2: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic write_reg(reg_idx_t idx, logic [B_W-1:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == REG_LOW_B) b_low_cur = val;
		else b_high_cur = val;
	endtask

	task automatic queue_random(int count);
		voxel_t v;
		for (int i = 0; i < count; i++) begin
			v.sig_lo = pick_sample();
			v.sig_hi = pick_sample();
			voxels_pending.push_back(v);
		end
	endtask

	task automatic wait_idle();
		while (voxels_pending.size() > 0 || estimates_due.size() > 0 || in_valid)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// b-value pairs: extremes, equal values, reversed order and overflow/underflow makers
	logic [B_W-1:0] cfg_lo[8] = '{14'd0, 14'd10000, 14'd16383, 14'd5000,
		14'd16383, 14'd1, 14'd1000, 14'd9000};
	logic [B_W-1:0] cfg_hi[8] = '{14'd10000, 14'd0, 14'd16383, 14'd5000,
		14'd1, 14'd16383, 14'd100, 14'd9001};

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed voxels at the reset b-values
		voxels_pending.push_back('{16'd0, 16'd500});
		voxels_pending.push_back('{16'd500, 16'd0});
		voxels_pending.push_back('{16'd0, 16'd0});
		voxels_pending.push_back('{16'd1, 16'd1});
		voxels_pending.push_back('{16'hFFFF, 16'hFFFF});
		voxels_pending.push_back('{16'd1, 16'hFFFF});
		voxels_pending.push_back('{16'hFFFF, 16'd1});
		voxels_pending.push_back('{16'hAAAA, 16'h5555});
		voxels_pending.push_back('{16'h5555, 16'hAAAA});
		voxels_pending.push_back('{16'd1000, 16'd500});
		voxels_pending.push_back('{16'd2, 16'd3});
		voxels_pending.push_back('{16'h8000, 16'h7FFF});
		voxels_pending.push_back('{16'd1, 16'd2});
		voxels_pending.push_back('{16'hFFFF, 16'd2});
		wait_idle();

		// Register extremes, a few voxels each, varying the stall pattern
		for (int p = 0; p < 8; p++) begin
			stall_mode = p % 3;
			write_reg(REG_LOW_B, cfg_lo[p]);
			write_reg(REG_HIGH_B, cfg_hi[p]);
			voxels_pending.push_back('{16'hFFFF, 16'd1});
			voxels_pending.push_back('{16'd1, 16'hFFFF});
			queue_random(10);
			wait_idle();
		end

		// Bulk traffic with a long receiver hold-off to back the pipeline up
		stall_mode = 1;
		gaps_on = 1'b0;
		write_reg(REG_LOW_B, 14'($urandom_range(0, 2000)));
		write_reg(REG_HIGH_B, 14'($urandom_range(2000, 10000)));
		queue_random(850);
		hold_req = 1'b1;
		wait_idle();
		gaps_on = 1'b1;

		// Back to the reset values with no stalls
		stall_mode = 0;
		write_reg(REG_LOW_B, 14'd100);
		write_reg(REG_HIGH_B, 14'd1000);
		queue_random(20);
		wait_idle();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && estimates_due.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
